FILE: design/wtsp_pkg.sv
// Shared types and codes for the world-to-screen projection pipeline.
// Self-contained; used by world_to_screen_projection.
package wtsp_pkg;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROJECT = 1'b1;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [13:0] OFF_COORD = 14'd10000;
  localparam logic [12:0] RESET_WIDTH  = 13'd1920;
  localparam logic [12:0] RESET_HEIGHT = 13'd1080;

  // Quotient bits produced by the divider, one per stage.
  localparam int QB = 31;

  typedef struct packed {
    logic        bad;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [11:0] bl;
    logic [11:0] bt;
    logic [11:0] br;
    logic [11:0] bb;
  } side_t;

endpackage

FILE: design/world_to_screen_projection.sv
// World point to pixel projection: matrix multiply, three pipelined
// dividers and viewport mapping. Depends on wtsp_pkg.
//
//  channel | direction | handshake                | payload
//  s_*     | in        | s_tvalid / s_tready      | s_tdata, s_tuser = req_type
//  m_*     | out       | m_tvalid / m_tready      | m_tdata, m_tuser = on_screen
//  cfg_*   | in        | cfg_wr_en, no wait       | cfg_addr, cfg_data
//
// One request per cycle unless the output stalls; project request steps are
// multiply, row sum, magnitude, 31 restoring divide stages (one quotient bit
// each), viewport multiply, border compare. Load requests write the matrix at
// accept and give no result. rst restores the identity matrix and a 1920x1080
// screen and empties the pipeline. A stalled output freezes every stage.
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], border_left[143:132], border_top[155:144],
  // border_right[167:156], border_bottom[179:168], zero fill
  input  logic [183:0] s_tdata,
  input  logic         s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  // screen_x[13:0], screen_y[27:14], zero fill
  output logic [31:0]  m_tdata,
  output logic         m_tuser,  // on_screen
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [12:0]  cfg_data
);

  localparam int QB = wtsp_pkg::QB;
  localparam int PW = 66 - FRAC_BITS;
  localparam int RW = PW + QB;
  localparam int SW = 64 - FRAC_BITS;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
  localparam logic signed [46:0] BIAS = (47'sd1 <<< (FRAC_BITS + 1)) - 47'sd1;

  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic signed [31:0] mat [0:15];

  logic advance;
  logic accept;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= wtsp_pkg::RESET_WIDTH;
      screen_height <= wtsp_pkg::RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        wtsp_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        wtsp_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= (i % 5 == 0) ? $signed(ONE) : 32'sd0;
      end
    end else if (accept && s_tuser == wtsp_pkg::REQ_LOAD) begin
      mat[s_tdata[3:0]] <= $signed(s_tdata[35:4]);
    end
  end

  // Stage 1: products, taken at accept so later loads cannot disturb them
  logic signed [31:0] pt [0:2];
  assign pt[0] = $signed(s_tdata[67:36]);
  assign pt[1] = $signed(s_tdata[99:68]);
  assign pt[2] = $signed(s_tdata[131:100]);

  logic               v1;
  logic signed [63:0] prod1 [0:11];
  logic signed [31:0] wcol1 [0:3];
  logic [47:0]        bord1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= accept && s_tuser == wtsp_pkg::REQ_PROJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1[r*3+c] <= mat[r*4+c] * pt[c];
        end
        wcol1[r] <= mat[r*4+3];
      end
      bord1 <= s_tdata[179:132];
    end
  end

  // Stage 2: floor shift and row sums
  logic               v2;
  logic signed [PW-1:0] row2 [0:3];
  logic [47:0]        bord2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        row2[r] <= PW'($signed(prod1[r*3][63:FRAC_BITS]))
                 + PW'($signed(prod1[r*3+1][63:FRAC_BITS]))
                 + PW'($signed(prod1[r*3+2][63:FRAC_BITS]))
                 + PW'(wcol1[r]);
      end
      bord2 <= bord1;
    end
  end

  // Stage 3: magnitudes, signs, zero and overflow checks
  logic [PW-1:0] mag [0:3];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mag[r] = row2[r][PW-1] ? PW'(-row2[r]) : PW'(row2[r]);
    end
  end

  logic [RW-1:0] lim3;
  logic          ovf3;
  assign lim3 = RW'(mag[3]) << (QB - FRAC_BITS);
  assign ovf3 = (RW'(mag[0]) >= lim3) || (RW'(mag[1]) >= lim3) || (RW'(mag[2]) >= lim3);

  logic            vd  [0:QB];
  logic [RW-1:0]   rx  [0:QB];
  logic [RW-1:0]   ry  [0:QB];
  logic [RW-1:0]   rz  [0:QB];
  logic [PW-1:0]   dd  [0:QB];
  logic [QB-1:0]   qx  [0:QB];
  logic [QB-1:0]   qy  [0:QB];
  logic [QB-1:0]   qz  [0:QB];
  wtsp_pkg::side_t sd  [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (advance) begin
      vd[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rx[0] <= RW'(mag[0]) << FRAC_BITS;
      ry[0] <= RW'(mag[1]) << FRAC_BITS;
      rz[0] <= RW'(mag[2]) << FRAC_BITS;
      dd[0] <= mag[3];
      qx[0] <= '0;
      qy[0] <= '0;
      qz[0] <= '0;
      sd[0].bad   <= (mag[3] == '0) || ovf3;
      sd[0].neg_x <= row2[0][PW-1] != row2[3][PW-1];
      sd[0].neg_y <= row2[1][PW-1] != row2[3][PW-1];
      sd[0].neg_z <= row2[2][PW-1] != row2[3][PW-1];
      sd[0].bl    <= bord2[11:0];
      sd[0].bt    <= bord2[23:12];
      sd[0].br    <= bord2[35:24];
      sd[0].bb    <= bord2[47:36];
    end
  end

  // Divide stages: stage j settles quotient bit QB-1-j of all three lanes
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] dsh;
    logic          gx, gy, gz;
    assign dsh = RW'(dd[j]) << (QB - 1 - j);
    assign gx  = rx[j] >= dsh;
    assign gy  = ry[j] >= dsh;
    assign gz  = rz[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (advance) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rx[j+1] <= gx ? rx[j] - dsh : rx[j];
        ry[j+1] <= gy ? ry[j] - dsh : ry[j];
        rz[j+1] <= gz ? rz[j] - dsh : rz[j];
        qx[j+1] <= {qx[j][QB-2:0], gx};
        qy[j+1] <= {qy[j][QB-2:0], gy};
        qz[j+1] <= {qz[j][QB-2:0], gz};
        dd[j+1] <= dd[j];
        sd[j+1] <= sd[j];
      end
    end
  end

  // Stage E: signed ndc, depth check, viewport multiply
  wtsp_pkg::side_t    se;
  logic [QB-1:0]      qzq;
  logic signed [31:0] nx, ny;
  logic signed [32:0] ax, ay;
  logic               zok;
  assign qzq = qz[QB];
  assign nx  = sd[QB].neg_x ? -$signed(32'(qx[QB])) : $signed(32'(qx[QB]));
  assign ny  = sd[QB].neg_y ? -$signed(32'(qy[QB])) : $signed(32'(qy[QB]));
  assign ax  = 33'(nx) + $signed({1'b0, ONE});
  assign ay  = 33'(ny) + $signed({1'b0, ONE});
  assign zok = !sd[QB].neg_z && (qzq != '0) && (32'(qzq) < ONE);

  logic               ve;
  logic               oke;
  logic signed [46:0] mx, my;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (advance) begin
      ve <= vd[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oke <= !sd[QB].bad && zok;
      se  <= sd[QB];
      mx  <= ax * $signed({1'b0, screen_width});
      my  <= ay * $signed({1'b0, screen_height});
    end
  end

  // Final stage: truncate toward zero, border compare, output register
  logic signed [46:0] px, py, limx, limy;
  logic               in_view;
  assign px   = (mx + (mx[46] ? BIAS : 47'sd0)) >>> (FRAC_BITS + 1);
  assign py   = (my + (my[46] ? BIAS : 47'sd0)) >>> (FRAC_BITS + 1);
  assign limx = $signed(47'(screen_width)) - $signed(47'(se.br));
  assign limy = $signed(47'(screen_height)) - $signed(47'(se.bb));
  assign in_view = oke && (px > $signed(47'(se.bl))) && (px < limx)
                 && (py > $signed(47'(se.bt))) && (py < limy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= in_view;
      m_tdata <= {4'b0000,
                  in_view ? py[13:0] : wtsp_pkg::OFF_COORD,
                  in_view ? px[13:0] : wtsp_pkg::OFF_COORD};
    end
  end

endmodule

FILE: bench/world_to_screen_projection_test.sv
// Self-checking bench for world_to_screen_projection: directed rows, then random phases.
// Each phase uses its own screen size. Every result is checked against a row's pixel or
// a fixed-point projection predictor. Depends on wtsp_pkg and the block itself.
`timescale 1ns / 100ps

module world_to_screen_projection_test;

  localparam int FRAC = 16;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam int PIPE_DEPTH = 40;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        on;
    logic [13:0] sx;
    logic [13:0] sy;
  } pixel_t;

  typedef struct packed {
    logic        req;
    logic [3:0]  idx;
    logic [31:0] coef;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [11:0] bl;
    logic [11:0] bt;
    logic [11:0] br;
    logic [11:0] bb;
    logic        typed;
    pixel_t      want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [12:0]  cfg_data = '0;

  // predictor state
  logic signed [31:0] matrix [16];
  logic [12:0] scr_w, scr_h;
  pixel_t pixel_q [$];
  int errors = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  world_to_screen_projection dut (.*);

  always #4 clk = ~clk;

  // Q-format divide, truncating; returns 0 on overflow
  function automatic bit q_div(longint num, longint den, output longint quo);
    longint unsigned n, d, q, r;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    quo = 0;
    if (q >= (64'd1 << (31 - FRAC))) return 1'b0;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    quo = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    return 1'b1;
  endfunction

  function automatic pixel_t project_pixel(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [11:0] bl, logic [11:0] bt,
                                           logic [11:0] br, logic [11:0] bb);
    longint v [4];
    longint acc [4];
    longint nx, ny, nz, pxl, pyl, w, h;
    pixel_t res;
    v[0] = longint'(signed'(x));
    v[1] = longint'(signed'(y));
    v[2] = longint'(signed'(z));
    v[3] = longint'(ONE);
    for (int r = 0; r < 4; r++) begin
      acc[r] = 0;
      for (int c = 0; c < 4; c++)
        acc[r] += (longint'(matrix[r*4+c]) * v[c]) >>> FRAC;
    end
    res = '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD};
    if (acc[3] == 0) return res;
    if (!q_div(acc[0], acc[3], nx) || !q_div(acc[1], acc[3], ny) ||
        !q_div(acc[2], acc[3], nz)) return res;
    if (!(nz > 0 && nz < longint'(ONE))) return res;
    w = longint'(scr_w);
    h = longint'(scr_h);
    pxl = ((nx + longint'(ONE)) * w) / (2 * longint'(ONE));
    pyl = ((ny + longint'(ONE)) * h) / (2 * longint'(ONE));
    if (pxl > longint'(bl) && pxl < w - longint'(br) &&
        pyl > longint'(bt) && pyl < h - longint'(bb)) begin
      res.on = 1'b1;
      res.sx = pxl[13:0];
      res.sy = pyl[13:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] srand(int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // drive one request and hold it until accepted; update the predictor on accept
  task automatic send_request(row_t rq);
    bit ok;
    int r;
    s_tvalid <= 1'b1;
    s_tuser <= rq.req;
    s_tdata <= {4'b0, rq.bb, rq.br, rq.bt, rq.bl, rq.pz, rq.py, rq.px, rq.coef, rq.idx};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    if (rq.req == wtsp_pkg::REQ_LOAD)
      matrix[rq.idx] = rq.coef;
    else if (rq.typed)
      pixel_q.push_back(rq.want);
    else
      pixel_q.push_back(project_pixel(rq.px, rq.py, rq.pz, rq.bl, rq.bt, rq.br, rq.bb));
    r = $urandom_range(0, 99);
    if (!quiet && r < 18) begin
      s_tvalid <= 1'b0;
      repeat (r < 15 ? $urandom_range(1, 3) : $urandom_range(20, 50)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == wtsp_pkg::CFG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  task automatic random_phase(int count, logic [12:0] w, logic [12:0] h, bit squeeze);
    row_t rq;
    bit persp;
    write_reg(wtsp_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(wtsp_pkg::CFG_SCREEN_HEIGHT, h);
    // well-formed matrix: affine rows, w row plain or perspective
    persp = $urandom_range(0, 1);
    for (int i = 0; i < 16; i++) begin
      rq = '0;
      rq.req = wtsp_pkg::REQ_LOAD;
      rq.idx = 4'(i);
      if (i < 12) rq.coef = srand(int'(ONE));
      else if (i == 14) rq.coef = persp ? ONE : 32'd0;
      else if (i == 15) rq.coef = persp ? srand(int'(HALF)) : ONE;
      else rq.coef = '0;
      send_request(rq);
    end
    if (squeeze) long_hold = 1'b1;
    for (int n = 0; n < count; n++) begin
      rq.req = ($urandom_range(0, 9) == 0) ? wtsp_pkg::REQ_LOAD : wtsp_pkg::REQ_PROJECT;
      rq.idx = 4'($urandom);
      rq.coef = ($urandom_range(0, 3) == 0) ? $urandom : srand(int'(ONE));
      if ($urandom_range(0, 4) != 0) begin
        rq.px = srand(2 * int'(ONE));
        rq.py = srand(2 * int'(ONE));
        rq.pz = srand(2 * int'(ONE));
      end else begin
        rq.px = $urandom;
        rq.py = $urandom;
        rq.pz = $urandom;
      end
      if ($urandom_range(0, 9) < 7) begin
        rq.bl = 12'($urandom_range(0, 40));
        rq.bt = 12'($urandom_range(0, 40));
        rq.br = 12'($urandom_range(0, 40));
        rq.bb = 12'($urandom_range(0, 40));
      end else begin
        rq.bl = 12'($urandom);
        rq.bt = 12'($urandom);
        rq.br = 12'($urandom);
        rq.bb = 12'($urandom);
      end
      rq.typed = 1'b0;
      send_request(rq);
    end
    drain();
  endtask

  // Output side: short and long gaps, plus one long hold-off when asked.
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
        long_hold = 1'b0;
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        gap--;
      end else begin
        m_tready <= 1'b1;
        if (!quiet) begin
          case ($urandom_range(0, 49))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            6: gap = $urandom_range(20, 60);
            default: gap = 0;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result on=%0b x=%0d y=%0d", m_tuser, m_tdata[13:0], m_tdata[27:14]);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tuser !== want.on) begin
          $error("on_screen: expected %0b, got %0b", want.on, m_tuser);
          errors++;
        end
        if (m_tdata[13:0] !== want.sx) begin
          $error("screen_x: expected %0d, got %0d", want.sx, m_tdata[13:0]);
          errors++;
        end
        if (m_tdata[27:14] !== want.sy) begin
          $error("screen_y: expected %0d, got %0d", want.sy, m_tdata[27:14]);
          errors++;
        end
      end
    end
  end

  // watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t rows [] = '{
      // identity matrix, 1920x1080
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, HALF, 12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b1, 14'd960, 14'd540}},
      '{wtsp_pkg::REQ_PROJECT, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, ONE, 12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_8000,
        12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      // quotient overflow
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h8000_0000, 32'd0, HALF,
        12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, HALF,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      // borders larger than the screen
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, HALF, 12'd4095, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, HALF,
        12'd0, 12'd4095, 12'd4095, 12'd4095,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, HALF,
        12'd959, 12'd539, 12'd959, 12'd539,
        1'b1, '{1'b1, 14'd960, 14'd540}},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd1,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h0000_C000, 32'hFFFF_4000, 32'h0000_FFFF,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      // zero w
      '{wtsp_pkg::REQ_LOAD, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, ONE, ONE, HALF, 12'd0, 12'd0, 12'd0, 12'd0,
        1'b1, '{1'b0, wtsp_pkg::OFF_COORD, wtsp_pkg::OFF_COORD}},
      // perspective divide: w = z + 1
      '{wtsp_pkg::REQ_LOAD, 4'd14, ONE, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_LOAD, 4'd15, ONE, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, HALF, 32'hFFFF_8000, ONE,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      // extreme coefficients
      '{wtsp_pkg::REQ_LOAD, 4'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, ONE,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_LOAD, 4'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{wtsp_pkg::REQ_PROJECT, 4'd0, 32'd0, 32'h0000_0100, 32'd0, ONE,
        12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0}
    };
    for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? ONE : 32'd0;
    scr_w = wtsp_pkg::RESET_WIDTH;
    scr_h = wtsp_pkg::RESET_HEIGHT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i]);
    drain();

    random_phase(100, 13'd1920, 13'd1080, 1'b0);
    random_phase(60, 13'd1, 13'd1, 1'b0);
    // block fills up behind a long output stall
    random_phase(100, 13'd8191, 13'd8191, 1'b1);
    quiet = 1'b1;
    random_phase(100, 13'd640, 13'd480, 1'b0);
    quiet = 1'b0;
    random_phase(40, 13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)), 1'b0);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
